// ----- rtl/core/phx_pkg.sv -----
// Shared types, constants and helpers for the Philox4x32 counter-based generator.
// No dependencies; phx_round, phx_unif and philox_counter_rng import this package.
package phx_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_W  = 64;
    localparam int UNIF_W = 54;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [UNIF_W-1:0] t_unif;

    typedef struct packed {
        t_word w0;
        t_word w1;
        t_word w2;
        t_word w3;
    } t_words;

    localparam t_word MUL_A  = 32'hD251_1F53;
    localparam t_word MUL_B  = 32'hCD9E_8D57;
    localparam t_word WEYL_A = 32'h9E37_79B9;
    localparam t_word WEYL_B = 32'hBB67_AE85;

    // top 53 bits of hi:lo as value * 2^54; zero maps to the smallest code
    function automatic t_unif uniform_code(input t_word hi, input t_word lo);
        logic [UNIF_W-2:0] j;
        j = {hi, lo[WORD_W-1:11]};
        if (j == '0) begin
            return t_unif'(1);
        end
        return {j, 1'b0};
    endfunction

endpackage

// ----- rtl/core/phx_if.sv -----
// Valid/ready channel interfaces for the Philox generator: input, output, config.
// No dependencies.
interface phx_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic        [31:0] stream_id;

    modport source (output valid, coord_x, coord_y, coord_z, stream_id, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, stream_id, output ready);
endinterface

interface phx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic [53:0] uniform_first;
    logic [53:0] uniform_second;

    modport source (output valid, word_zero, word_one, word_two, word_three,
                    uniform_first, uniform_second, input ready);
    modport sink   (input valid, word_zero, word_one, word_two, word_three,
                    uniform_first, uniform_second, output ready);
endinterface

interface phx_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed_key;

    modport source (output valid, seed_key, input ready);
    modport sink   (input valid, seed_key, output ready);
endinterface

// ----- rtl/core/phx_round.sv -----
// One Philox round as a pipeline stage: two 32x32 products registered, mix on the way out.
// Depends on phx_pkg.
module phx_round
    import phx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_words i_words,
    input  t_key   i_rkey,
    output logic   o_valid,
    output t_words o_words
);

    logic                r_valid;
    logic [2*WORD_W-1:0] r_pa;
    logic [2*WORD_W-1:0] r_pb;
    t_word               r_c1;
    t_word               r_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= (2*WORD_W)'(MUL_A) * (2*WORD_W)'(i_words.w0);
            r_pb <= (2*WORD_W)'(MUL_B) * (2*WORD_W)'(i_words.w2);
            r_c1 <= i_words.w1;
            r_c3 <= i_words.w3;
        end
    end

    // key low word mixes into word 0, high word into word 2
    assign o_words.w0 = r_pb[2*WORD_W-1:WORD_W] ^ r_c1 ^ i_rkey[WORD_W-1:0];
    assign o_words.w1 = r_pb[WORD_W-1:0];
    assign o_words.w2 = r_pa[2*WORD_W-1:WORD_W] ^ r_c3 ^ i_rkey[KEY_W-1:WORD_W];
    assign o_words.w3 = r_pa[WORD_W-1:0];
    assign o_valid    = r_valid;

endmodule

// ----- rtl/core/phx_unif.sv -----
// Output register of the generator: final words plus the two open uniform codes.
// Depends on phx_pkg.
module phx_unif
    import phx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_words i_words,
    output logic   o_valid,
    output t_words o_words,
    output t_unif  o_unif_a,
    output t_unif  o_unif_b
);

    logic   r_valid;
    t_words r_words;
    t_unif  r_unif_a;
    t_unif  r_unif_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_words  <= i_words;
            r_unif_a <= uniform_code(i_words.w0, i_words.w1);
            r_unif_b <= uniform_code(i_words.w2, i_words.w3);
        end
    end

    assign o_valid  = r_valid;
    assign o_words  = r_words;
    assign o_unif_a = r_unif_a;
    assign o_unif_b = r_unif_b;

endmodule

// ----- rtl/core/philox_counter_rng.sv -----
// Top level of the Philox4x32 counter-based generator: input stage, round chain, output stage.
// Depends on phx_pkg, phx_if, phx_round and phx_unif.
//
//  channel  | dir | payload                                         | accepted when
//  i_in     | in  | coord_x, coord_y, coord_z, stream_id            | valid && ready
//  o_out    | out | word_zero..word_three, uniform_first/second     | valid && ready
//  i_cfg    | in  | seed_key                                        | valid && ready
//
// One word per cycle in and out while the chain advances; the pipeline is the input register, one
// stage per round holding the two products, and the output register with the uniform codes.
// The whole chain advances together whenever the output register is empty or taken.
// Reset clears the valid bits and loads the round keys for a zero seed; i_cfg is always ready.
module philox_counter_rng
    import phx_pkg::*;
#(
    parameter int ROUNDS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    phx_in_if.sink    i_in,
    phx_out_if.source o_out,
    phx_cfg_if.sink   i_cfg
);

    logic   w_en;
    logic   r_in_valid;
    t_words r_in_words;
    t_key   r_rkey  [ROUNDS];
    logic   w_valid [ROUNDS+1];
    t_words w_words [ROUNDS+1];
    t_words w_out_words;

    assign w_en        = !o_out.valid || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    // per-round keys, seed plus a multiple of the Weyl constants
    for (genvar g = 0; g < ROUNDS; g++) begin : g_key
        localparam t_word OFS_A = WEYL_A * 32'(g);
        localparam t_word OFS_B = WEYL_B * 32'(g);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rkey[g] <= {OFS_B, OFS_A};
            end else if (i_cfg.valid && i_cfg.ready) begin
                r_rkey[g] <= {i_cfg.seed_key[KEY_W-1:WORD_W] + OFS_B,
                              i_cfg.seed_key[WORD_W-1:0] + OFS_A};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_words <= {t_word'(i_in.coord_x), t_word'(i_in.coord_y),
                           t_word'(i_in.coord_z), t_word'(i_in.stream_id)};
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_words[0] = r_in_words;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        phx_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_words (w_words[g]),
            .i_rkey  (r_rkey[g]),
            .o_valid (w_valid[g+1]),
            .o_words (w_words[g+1])
        );
    end

    phx_unif u_unif (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_valid[ROUNDS]),
        .i_words  (w_words[ROUNDS]),
        .o_valid  (o_out.valid),
        .o_words  (w_out_words),
        .o_unif_a (o_out.uniform_first),
        .o_unif_b (o_out.uniform_second)
    );

    assign o_out.word_zero  = w_out_words.w0;
    assign o_out.word_one   = w_out_words.w1;
    assign o_out.word_two   = w_out_words.w2;
    assign o_out.word_three = w_out_words.w3;

endmodule

// ----- rtl/core/phx_checker.sv -----
// Port-level checks for philox_counter_rng, attached by the bind at the end of this file.
// Depends on the top level's ports only.
module phx_checker #(
    parameter int ROUNDS = 10
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] word_zero,
    input logic [31:0] word_one,
    input logic [53:0] uniform_first,
    input logic [53:0] uniform_second
);

    localparam int CNT_W = $clog2(ROUNDS + 4);

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = in_valid && in_ready;
    assign w_out_acc = out_valid && out_ready;

    // words in flight between input and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (!w_in_acc && w_out_acc && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> r_cnt != '0)
        else $error("output word without a matching input word");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ROUNDS + 2))
        else $error("more words in flight than pipeline stages");

    a_unif_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (uniform_first == {word_zero, word_one[31:11], 1'b0}) ||
                      (uniform_first == 54'd1 && word_zero == '0 && word_one[31:11] == '0))
        else $error("uniform_first does not follow words zero and one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(uniform_second))
        else $error("stalled output word changed");

endmodule

bind philox_counter_rng phx_checker #(.ROUNDS(ROUNDS)) u_phx_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .in_valid       (i_in.valid),
    .in_ready       (i_in.ready),
    .out_valid      (o_out.valid),
    .out_ready      (o_out.ready),
    .word_zero      (o_out.word_zero),
    .word_one       (o_out.word_one),
    .uniform_first  (o_out.uniform_first),
    .uniform_second (o_out.uniform_second)
);
